>>> rtl/core/lb64_pkg.sv
`timescale 1ns / 1ps

package lb64_pkg;

    // Width of one stored slot: six value bits and a padding flag on top.
    localparam int SLOT_W = 7;
    localparam int VAL_W  = 6;
    localparam int PAD_BIT = 6;

    // Number of slots kept between items (the fourth never needs storing).
    localparam int SLOTS_HELD = 3;

    // Codes returned by the character lookup.
    localparam logic [7:0] CODE_PAD  = 8'd64;
    localparam logic [7:0] CODE_SKIP = 8'd255;

    // Offsets of the alphabet ranges and the two symbol values.
    localparam logic [7:0] LOWER_BASE = 8'd26;
    localparam logic [7:0] DIGIT_BASE = 8'd52;
    localparam logic [7:0] PLUS_VAL   = 8'd62;
    localparam logic [7:0] SLASH_VAL  = 8'd63;

    // Character codes.
    localparam logic [7:0] CHR_UPPER_A = 8'h41;
    localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHR_ZERO    = 8'h30;
    localparam logic [7:0] CHR_NINE    = 8'h39;
    localparam logic [7:0] CHR_PLUS    = 8'h2B;
    localparam logic [7:0] CHR_SLASH   = 8'h2F;
    localparam logic [7:0] CHR_EQUALS  = 8'h3D;

    typedef logic [SLOT_W-1:0] slot_t;

    // Maps a character to 0..63, to the padding code, or to the skip code.
    function automatic logic [7:0] classify(input logic [7:0] c);
        logic [7:0] r;
        case (c) inside
            [CHR_UPPER_A:CHR_UPPER_Z]: r = c - CHR_UPPER_A;
            [CHR_LOWER_A:CHR_LOWER_Z]: r = c - CHR_LOWER_A + LOWER_BASE;
            [CHR_ZERO:CHR_NINE]:       r = c - CHR_ZERO + DIGIT_BASE;
            CHR_PLUS:                  r = PLUS_VAL;
            CHR_SLASH:                 r = SLASH_VAL;
            CHR_EQUALS:                r = CODE_PAD;
            default:                   r = CODE_SKIP;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/lenient_base64_decoder.sv
`timescale 1ns / 1ps

// Lenient base64 decoder.
// The slave channel carries one character per item in s_tdata, with s_tlast
// on the final character of a text. Characters outside the alphabet are
// skipped and '=' counts as padding. The master channel carries decoded
// bytes in m_tdata; m_tlast marks the last byte that one input item caused
// (an item causes none, one, two or three bytes).
// An accepted item is held in the input register, where the lookup and
// the group decode run; its bytes enter the result register at the edge
// on which the item leaves the input register, and are shown from there.
// Items that cause no byte pass at one per cycle whatever the master side
// does. An item that causes bytes waits in the input register until the
// result register is empty or giving its final byte; the result register
// sends one byte per cycle while m_tready is high, so four-character groups
// then flow at one character per cycle. A stalled receiver holds the result
// register and, once a byte-causing item waits behind it, s_tready falls.
// Reset empties both registers and clears the open group and the halt flag;
// the decoder is ready for a new text as soon as reset is released.
module lenient_base64_decoder
    import lb64_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] byte_value
    output logic       m_tlast    // last_of_run
);

    // Input register.
    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic       eot_reg;

    // Open group state.
    slot_t      slot_reg  [SLOTS_HELD];
    slot_t      slot_next [SLOTS_HELD];
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       halted_reg;
    logic       halted_next;

    // Result register.
    logic [7:0] res_byte_reg [SLOTS_HELD];
    logic [1:0] left_reg;
    logic [1:0] idx_reg;

    // Decode datapath.
    logic [7:0] code;
    logic       skip;
    slot_t      g0, g1, g2, g3;
    logic [2:0] n_slots;
    logic       do_dec;
    logic       bad;
    logic [1:0] k;
    logic [7:0] b0, b1, b2;
    logic       res_free;
    logic       advance;
    logic       load;

    // Lookup and group assembly for the item in the input register.
    always_comb
    begin
        code        = classify(char_reg);
        skip        = (code == CODE_SKIP);
        slot_next   = slot_reg;
        cnt_next    = cnt_reg;
        g0          = slot_reg[0];
        g1          = slot_reg[1];
        g2          = slot_reg[2];
        g3          = code[SLOT_W-1:0];
        n_slots     = 3'd4;
        do_dec      = 1'b0;
        if (!halted_reg)
        begin
            if (!skip)
            begin
                if (cnt_reg == 2'd3)
                begin
                    // Fourth slot completes the group.
                    do_dec   = 1'b1;
                    cnt_next = 2'd0;
                end
                else
                begin
                    slot_next[cnt_reg] = code[SLOT_W-1:0];
                    cnt_next           = cnt_reg + 2'd1;
                end
            end
            // A text ending with two or three slots filled closes the group.
            if (eot_reg && (cnt_next >= 2'd2))
            begin
                g0      = slot_next[0];
                g1      = slot_next[1];
                g2      = slot_next[2];
                g3      = '0;
                n_slots = {1'b0, cnt_next};
                do_dec  = 1'b1;
            end
        end
    end

    // Group decode: padding in a leading slot halts the text.
    always_comb
    begin
        bad         = g0[PAD_BIT] | g1[PAD_BIT];
        halted_next = halted_reg | (do_dec & bad);
        b0          = {g0[VAL_W-1:0], g1[VAL_W-1:VAL_W-2]};
        b1          = {g1[VAL_W-3:0], g2[VAL_W-1:2]};
        b2          = {g2[1:0], g3[VAL_W-1:0]};
        if (!do_dec || bad)
        begin
            k = 2'd0;
        end
        else if ((n_slots > 3'd2) && !g2[PAD_BIT])
        begin
            if ((n_slots > 3'd3) && !g3[PAD_BIT])
            begin
                k = 2'd3;
            end
            else
            begin
                k = 2'd2;
            end
        end
        else
        begin
            k = 2'd1;
        end
    end

    // Handshake: an item leaves the input register when its bytes fit.
    assign res_free = (left_reg == 2'd0) || ((left_reg == 2'd1) && m_tready);
    assign advance  = in_valid_reg && (res_free || (k == 2'd0));
    assign load     = advance && (k != 2'd0);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = (left_reg != 2'd0);
    assign m_tdata  = res_byte_reg[idx_reg];
    assign m_tlast  = (left_reg == 2'd1);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            cnt_reg      <= 2'd0;
            halted_reg   <= 1'b0;
            left_reg     <= 2'd0;
            idx_reg      <= 2'd0;
            for (int i = 0; i < SLOTS_HELD; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            // Group state moves on; the final character clears it.
            if (advance)
            begin
                if (eot_reg)
                begin
                    cnt_reg    <= 2'd0;
                    halted_reg <= 1'b0;
                    for (int i = 0; i < SLOTS_HELD; i++)
                    begin
                        slot_reg[i] <= '0;
                    end
                end
                else
                begin
                    cnt_reg    <= cnt_next;
                    halted_reg <= halted_next;
                    slot_reg   <= slot_next;
                end
            end
            // Result register: load a new run or step through the current one.
            if (load)
            begin
                left_reg <= k;
                idx_reg  <= 2'd0;
            end
            else if (m_tvalid && m_tready)
            begin
                left_reg <= left_reg - 2'd1;
                idx_reg  <= idx_reg + 2'd1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            char_reg <= s_tdata;
            eot_reg  <= s_tlast;
        end
        if (load)
        begin
            res_byte_reg[0] <= b0;
            res_byte_reg[1] <= b1;
            res_byte_reg[2] <= b2;
        end
    end

endmodule

>>> rtl/core/lb64_checker.sv
`timescale 1ns / 1ps

module lb64_checker
    import lb64_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // Bytes sent since the last end of a run.
    logic [1:0] run_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_cnt_reg <= 2'd0;
        end
        else if (m_tvalid && m_tready)
        begin
            run_cnt_reg <= m_tlast ? 2'd0 : (run_cnt_reg + 2'd1);
        end
    end

    // A stalled byte holds its value and its end marker.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output item changed");

    // One input item never causes more than three bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (run_cnt_reg == 2'd2)) |-> m_tlast)
    else $error("run of output items longer than three");

    // With nothing waiting on the output, the decoder takes input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
    else $error("input stalled while output is empty");

    // Straight after reset no output byte is shown.
    assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
    else $error("output item shown straight after reset");

endmodule

bind lenient_base64_decoder lb64_checker u_lb64_checker (.*);
